FILE: rtl/bfa_pkg.sv
// shared types and constants for the best-fit block allocator
`timescale 1ns / 1ps
package bfa_pkg;
	localparam int unsigned MAX_BLOCKS_DEF   = 64;
	localparam int unsigned HEADER_BYTES_DEF = 4;
	localparam logic [31:0] HEAP_TOP_RESET   = 32'd65528;

	localparam logic [1:0] REG_HEAP_TOP = 2'd0;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_NO_SPACE   = 3'd1;
	localparam logic [2:0] ST_TABLE_FULL = 3'd2;
	localparam logic [2:0] ST_ZERO_SIZE  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_RD,
		S_EV,
		S_DEC,
		S_SH_RD,
		S_SH_WR,
		S_OUT
	} state_t;
endpackage

FILE: rtl/best_fit_block_allocator_core.sv
// best-fit allocator top level: sequencer, scan unit and configuration port
// allocate: scans every entry, then moves entries up to open a slot; no space skips the move
// free: scans until the matching entry, then moves the later entries down over it
// zero size, full table, null free and free of a tiny address return without a table scan
// throughput: one item at a time, set by the single table read port and shared scan unit
// reset: block count cleared, heap_top set to 65528; table contents are not cleared
`timescale 1ns / 1ps
module best_fit_block_allocator_core
	import bfa_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [31:0] request_size,
	input  logic [31:0] free_address,
	input  logic [31:0] stack_limit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_address,
	output logic [2:0]  status
);
	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CW = AW + 1;
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);

	state_t state_q, state_d;

	logic [31:0]   heap_top_q;
	logic [CW-1:0] count_q, idx_q, pos_q, best_idx_q;
	logic          cmd_q, found_q, ins_q;
	logic [31:0]   size_q, target_q, lim_q, last_q, best_gap_q, best_end_q, na_q;
	logic [32:0]   need_q;
	logic [31:0]   res_addr_q, out_addr_q;
	logic [2:0]    res_st_q, out_st_q;
	logic          out_valid_q;

	logic          we;
	logic [CW-1:0] waddr_c, raddr_c;
	logic [63:0]   wdata, rdata;
	logic [31:0]   e_addr, e_size, gap;
	logic [33:0]   end34;
	logic          fits, better;

	bfa_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr_c[AW-1:0]),
		.wdata(wdata),
		.raddr(raddr_c[AW-1:0]),
		.rdata(rdata)
	);

	assign e_addr = rdata[63:32];
	assign e_size = rdata[31:0];
	assign end34  = {2'b00, e_addr} + {2'b00, e_size} + {2'b00, HDR32};
	assign fits   = (end34[33:32] == 2'b00) && (end34[31:0] <= last_q);
	assign gap    = last_q - end34[31:0];
	assign better = fits && (need_q <= {1'b0, gap}) && (!found_q || gap < best_gap_q);

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == REG_HEAP_TOP) ? heap_top_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_top_q <= HEAP_TOP_RESET;
		end else if (psel && penable && pwrite && paddr == REG_HEAP_TOP) begin
			heap_top_q <= pwdata;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (in_valid) state_d = S_CHK;
			S_CHK: begin
				if (cmd_q == CMD_ALLOC) begin
					if (size_q == 32'd0 || count_q >= MAXC) state_d = S_OUT;
					else if (count_q == '0) state_d = S_DEC;
					else state_d = S_RD;
				end else begin
					if (target_q == 32'd0 || target_q < HDR32 || count_q == '0) state_d = S_OUT;
					else state_d = S_RD;
				end
			end
			S_RD: state_d = S_EV;
			S_EV: begin
				if (cmd_q == CMD_ALLOC) begin
					state_d = (idx_q + CW'(1) == count_q) ? S_DEC : S_RD;
				end else if (e_addr == target_q - HDR32) begin
					state_d = (idx_q + CW'(1) < count_q) ? S_SH_RD : S_OUT;
				end else begin
					state_d = (idx_q + CW'(1) == count_q) ? S_OUT : S_RD;
				end
			end
			S_DEC: begin
				if (found_q) state_d = (count_q > best_idx_q) ? S_SH_RD : S_SH_WR;
				else if (need_q > {1'b0, last_q} || lim_q > last_q - need_q[31:0])
					state_d = S_OUT;
				else state_d = S_SH_WR;
			end
			S_SH_RD: state_d = S_SH_WR;
			S_SH_WR: begin
				if (ins_q) begin
					if (idx_q == pos_q) state_d = S_OUT;
					else state_d = (idx_q - CW'(1) > pos_q) ? S_SH_RD : S_SH_WR;
				end else begin
					state_d = ((CW+1)'(idx_q) + (CW+1)'(2) < (CW+1)'(count_q)) ? S_SH_RD : S_OUT;
				end
			end
			S_OUT: if (!out_valid_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = (state_q == S_IDLE);
		raddr_c  = idx_q;
		we       = 1'b0;
		waddr_c  = idx_q;
		wdata    = rdata;
		case (state_q)
			S_SH_RD: raddr_c = ins_q ? idx_q - CW'(1) : idx_q + CW'(1);
			S_SH_WR: begin
				we = 1'b1;
				if (ins_q && idx_q == pos_q) wdata = {na_q, size_q};
			end
			default: raddr_c = idx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == S_SH_WR && ins_q && idx_q == pos_q) count_q <= count_q + CW'(1);
			if (state_q == S_EV && cmd_q == CMD_FREE && e_addr == target_q - HDR32 &&
			    idx_q + CW'(1) >= count_q) count_q <= count_q - CW'(1);
			if (state_q == S_SH_WR && !ins_q &&
			    (CW+1)'(idx_q) + (CW+1)'(2) >= (CW+1)'(count_q)) count_q <= count_q - CW'(1);
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q    <= cmd;
				size_q   <= request_size;
				target_q <= free_address;
				lim_q    <= stack_limit;
				need_q   <= {1'b0, request_size} + {1'b0, HDR32};
			end
			S_CHK: begin
				idx_q    <= '0;
				last_q   <= heap_top_q;
				found_q  <= 1'b0;
				res_addr_q <= 32'd0;
				if (cmd_q == CMD_ALLOC) begin
					if (size_q == 32'd0) res_st_q <= ST_ZERO_SIZE;
					else if (count_q >= MAXC) res_st_q <= ST_TABLE_FULL;
				end else begin
					if (target_q == 32'd0) res_st_q <= ST_OK;
					else res_st_q <= ST_NOT_FOUND;
				end
			end
			S_EV: begin
				if (cmd_q == CMD_ALLOC) begin
					if (better) begin
						found_q    <= 1'b1;
						best_gap_q <= gap;
						best_idx_q <= idx_q;
						best_end_q <= end34[31:0];
					end
					last_q <= e_addr;
					idx_q  <= idx_q + CW'(1);
				end else if (e_addr == target_q - HDR32) begin
					ins_q    <= 1'b0;
					res_st_q <= ST_OK;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_DEC: begin
				ins_q <= 1'b1;
				idx_q <= count_q;
				if (found_q) begin
					pos_q <= best_idx_q;
					na_q  <= best_end_q;
					res_addr_q <= best_end_q + HDR32;
					res_st_q   <= ST_OK;
				end else begin
					pos_q <= count_q;
					na_q  <= last_q - need_q[31:0];
					if (need_q > {1'b0, last_q} || lim_q > last_q - need_q[31:0]) begin
						res_st_q <= ST_NO_SPACE;
					end else begin
						res_addr_q <= last_q - need_q[31:0] + HDR32;
						res_st_q   <= ST_OK;
					end
				end
			end
			S_SH_WR: begin
				if (ins_q) begin
					if (idx_q != pos_q) idx_q <= idx_q - CW'(1);
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_addr_q <= res_addr_q;
					out_st_q   <= res_st_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid      = out_valid_q;
	assign result_address = out_addr_q;
	assign status         = out_st_q;
endmodule

FILE: rtl/bfa_table.sv
// block table memory, one write port and one registered read port
`timescale 1ns / 1ps
module bfa_table
	import bfa_pkg::*;
#(
	parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
	localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
